// File: design/msm_pkg.sv
// Shared types and codes for the multi-pattern string matcher.
// Depends on nothing; imported by the controller, datapath and top level.
package msm_pkg;

    localparam int NODES_DEF    = 256;
    localparam int POS_BITS_DEF = 32;

    localparam logic [1:0] OP_PATTERN = 2'd0;
    localparam logic [1:0] OP_BUILD   = 2'd1;
    localparam logic [1:0] OP_TEXT    = 2'd2;
    localparam logic [1:0] OP_NOP     = 2'd3;

    localparam logic [1:0] KIND_STORED = 2'd0;
    localparam logic [1:0] KIND_FULL   = 2'd1;
    localparam logic [1:0] KIND_BUILT  = 2'd2;
    localparam logic [1:0] KIND_MATCH  = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic       last;
        logic       first;
    } in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] match_start;
        logic [31:0] end_index;
        logic [7:0]  pattern_node;
        logic [7:0]  pattern_length;
    } out_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_DISPATCH,
        ST_P_RD, ST_P_UPD, ST_P_FIN,
        ST_B_INIT, ST_B_RD, ST_B_CHILD, ST_B_NEXT, ST_B_POP, ST_B_CUR, ST_B_FC,
        ST_T_INIT,
        ST_FB_CHK, ST_FB_EDGE, ST_FB_FAIL, ST_E_RD, ST_E_USE,
        ST_C_CHK, ST_C_EV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic p_rd;
        logic p_upd;
        logic p_fin;
        logic b_init;
        logic b_rd;
        logic b_child;
        logic b_next;
        logic b_pop;
        logic b_cur;
        logic b_fc;
        logic t_init;
        logic fb_edge;
        logic fb_fail;
        logic e_use;
        logic c_chk;
        logic c_ev;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic       clr_done;
        logic [1:0] op;
        logic       last;
        logic       ins_failed;
        logic       out_free;
        logic       child_zero;
        logic       is_root;
        logic       chr_last;
        logic       queue_empty;
        logic       walk_zero;
        logic       steps_full;
        logic       is_build;
        logic       mark;
        logic       len_ok;
    } status_t;

endpackage

// File: design/multi_pattern_string_matcher.sv
// Multi-pattern byte matcher (trie with failure links). Top level.
// Depends on msm_pkg, msm_ctrl and msm_dp.
//
// After reset the block sweeps its trie memory clear, one entry a cycle,
// before it takes its first word. Items run one at a time through a state
// machine whose pace is set by the single read port of each table memory. A
// pattern byte passes through a read, an update and a finish state, and the
// emit state as well when it ends a pattern; once a pattern has been dropped
// its bytes skip the read and update states. A text byte follows failure
// links from the node where the scan stands and then examines the nodes of
// the output chain, each walk bounded at NODES steps. A build visits every
// byte code of each queued node, plus the fall-back walk for each child. The
// last step of an item that reports waits while the output register still
// holds an unaccepted result. A result waits in an output register while the
// next word is taken.
module multi_pattern_string_matcher
    import msm_pkg::*;
#(
    parameter int NODES    = NODES_DEF,
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    cmd_t    cmd;
    status_t stat;

    msm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    msm_dp #(
        .NODES    (NODES),
        .POS_BITS (POS_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

// File: design/msm_ctrl.sv
// Sequencer for the matcher: one state machine that steps the datapath.
// Depends on msm_pkg for the state, command and status types.
module msm_ctrl
    import msm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t stat,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Advance state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:    if (stat.clr_done) state_next = ST_IDLE;
            ST_IDLE:     if (s_valid) state_next = ST_DISPATCH;
            ST_DISPATCH: begin
                unique case (stat.op)
                    OP_PATTERN: state_next = stat.ins_failed ? ST_P_FIN : ST_P_RD;
                    OP_BUILD:   state_next = ST_B_INIT;
                    OP_TEXT:    state_next = ST_T_INIT;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_P_RD:     state_next = ST_P_UPD;
            ST_P_UPD:    state_next = ST_P_FIN;
            ST_P_FIN:    state_next = stat.last ? ST_EMIT : ST_IDLE;
            ST_B_INIT:   state_next = ST_B_RD;
            ST_B_RD:     state_next = ST_B_CHILD;
            ST_B_CHILD: begin
                priority if (stat.child_zero || stat.is_root) state_next = ST_B_NEXT;
                else state_next = ST_FB_CHK;
            end
            ST_B_NEXT:   state_next = stat.chr_last ? ST_B_POP : ST_B_RD;
            ST_B_POP:    state_next = stat.queue_empty ? ST_EMIT : ST_B_CUR;
            ST_B_CUR:    state_next = ST_B_FC;
            ST_B_FC:     state_next = ST_B_RD;
            ST_T_INIT:   state_next = ST_FB_CHK;
            ST_FB_CHK:   state_next = stat.walk_zero ? ST_E_RD : ST_FB_EDGE;
            ST_FB_EDGE: begin
                priority if (!stat.child_zero || stat.steps_full) state_next = ST_E_RD;
                else state_next = ST_FB_FAIL;
            end
            ST_FB_FAIL:  state_next = ST_FB_CHK;
            ST_E_RD:     state_next = ST_E_USE;
            ST_E_USE:    state_next = stat.is_build ? ST_B_NEXT : ST_C_CHK;
            ST_C_CHK: begin
                priority if (stat.walk_zero || stat.steps_full) state_next = ST_IDLE;
                else state_next = ST_C_EV;
            end
            ST_C_EV: begin
                priority if (!stat.mark) state_next = ST_C_CHK;
                else if (stat.len_ok) state_next = ST_EMIT;
                else state_next = ST_IDLE;
            end
            ST_EMIT:     if (stat.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Drive commands
    always_comb begin
        cmd      = '0;
        s_ready  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:    cmd.clr_step = 1'b1;
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_P_RD:     cmd.p_rd = 1'b1;
            ST_P_UPD:    cmd.p_upd = 1'b1;
            ST_P_FIN:    cmd.p_fin = stat.last;
            ST_B_INIT:   cmd.b_init = 1'b1;
            ST_B_RD:     cmd.b_rd = 1'b1;
            ST_B_CHILD:  cmd.b_child = 1'b1;
            ST_B_NEXT:   cmd.b_next = 1'b1;
            ST_B_POP:    cmd.b_pop = 1'b1;
            ST_B_CUR:    cmd.b_cur = 1'b1;
            ST_B_FC:     cmd.b_fc = 1'b1;
            ST_T_INIT:   cmd.t_init = 1'b1;
            ST_FB_EDGE:  cmd.fb_edge = 1'b1;
            ST_FB_FAIL:  cmd.fb_fail = 1'b1;
            ST_E_USE:    cmd.e_use = 1'b1;
            ST_C_CHK:    cmd.c_chk = 1'b1;
            ST_C_EV:     cmd.c_ev = 1'b1;
            ST_EMIT:     cmd.emit = 1'b1;
            default:     cmd = '0;
        endcase
    end

endmodule

// File: design/msm_dp.sv
// Datapath for the matcher: trie, failure, mark and queue memories,
// insertion and walk registers, result register. Depends on msm_pkg.
module msm_dp
    import msm_pkg::*;
#(
    parameter int NODES    = NODES_DEF,
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  in_t     s_data,
    output logic    m_valid,
    input  logic    m_ready,
    output out_t    m_data,
    input  cmd_t    cmd,
    output status_t stat
);

    localparam int NB = $clog2(NODES);
    localparam int CW = NB + 1;
    localparam int AW = NB + 8;
    localparam int GD = NODES * 256;
    localparam int PW = POS_BITS + 1;

    in_t                 item_reg;
    logic [CW-1:0]       ncount_reg, steps_reg, head_reg, tail_reg;
    logic [NB-1:0]       ins_node_reg, scan_reg, walk_reg, cur_reg, child_reg, fcur_reg;
    logic [7:0]          depth_reg, chr_reg;
    logic                failed_reg, root_reg;
    logic [POS_BITS-1:0] pos_reg, posc_reg;
    logic [AW-1:0]       clr_reg;
    out_t                res_reg, res_next, m_data_reg;
    logic                m_valid_reg;

    // memories and their registered read data
    logic [NB-1:0] goto_mem  [GD];
    logic [NB-1:0] fail_mem  [NODES];
    logic          mark_mem  [NODES];
    logic [7:0]    mlen_mem  [NODES];
    logic [NB-1:0] queue_mem [NODES];
    logic [NB-1:0] goto_q, fail_q, queue_q;
    logic          mark_q;
    logic [7:0]    mlen_q;

    logic          is_build, child0, p_full, steps_full, enq, qw_en, out_free;
    logic [7:0]    key;
    logic [AW-1:0] g_ra, g_wa;
    logic [NB-1:0] g_wd, f_ra, f_wa, f_wd, q_wd;
    logic          g_we, f_we, m_we, m_wd;
    logic [PW-1:0] posp1;
    logic [POS_BITS-1:0] pos_base, pos_inc;

    assign is_build   = (item_reg.op == OP_BUILD);
    assign key        = is_build ? chr_reg : item_reg.data;
    assign child0     = (goto_q == '0);
    assign p_full     = (ncount_reg >= CW'(NODES));
    assign steps_full = (steps_reg >= CW'(NODES));
    assign out_free   = !m_valid_reg || m_ready;
    assign posp1      = {1'b0, posc_reg} + PW'(1);
    assign pos_base   = item_reg.first ? '0 : pos_reg;
    assign pos_inc    = (&pos_base) ? pos_base : pos_base + POS_BITS'(1);

    // Queue children: top-level children directly, deeper ones after the edge lookup
    assign enq   = (cmd.b_child && !child0 && root_reg) || (cmd.e_use && is_build);
    assign qw_en = enq && (tail_reg < CW'(NODES));
    assign q_wd  = cmd.b_child ? goto_q : child_reg;

    // Select goto table address and write
    always_comb begin
        priority if (cmd.p_rd || cmd.p_upd) g_ra = {ins_node_reg, item_reg.data};
        else if (cmd.b_rd) g_ra = {cur_reg, chr_reg};
        else g_ra = {walk_reg, key};
        g_we = 1'b0;
        g_wa = g_ra;
        g_wd = ncount_reg[NB-1:0];
        priority if (cmd.clr_step) begin
            g_we = 1'b1;
            g_wa = clr_reg;
            g_wd = '0;
        end else if (cmd.p_upd && child0 && !failed_reg && !p_full) begin
            g_we = 1'b1;
        end
    end

    // Select failure table address and write
    always_comb begin
        f_ra = cmd.b_cur ? queue_q : walk_reg;
        f_we = 1'b0;
        f_wa = child_reg;
        f_wd = goto_q;
        priority if (cmd.clr_step) begin
            f_we = 1'b1;
            f_wa = clr_reg[AW-1:8];
            f_wd = '0;
        end else if (cmd.b_child && !child0 && root_reg) begin
            f_we = 1'b1;
            f_wa = goto_q;
            f_wd = '0;
        end else if (cmd.e_use && is_build) begin
            f_we = 1'b1;
        end
    end

    // Mark writes: clear sweep or pattern end
    always_comb begin
        m_we = cmd.clr_step || (cmd.p_fin && !failed_reg);
        m_wd = !cmd.clr_step;
    end

    always_ff @(posedge aclk) begin
        if (g_we) goto_mem[g_wa] <= g_wd;
        goto_q <= goto_mem[g_ra];
    end

    always_ff @(posedge aclk) begin
        if (f_we) fail_mem[f_wa] <= f_wd;
        fail_q <= fail_mem[f_ra];
    end

    always_ff @(posedge aclk) begin
        if (m_we) mark_mem[cmd.clr_step ? clr_reg[AW-1:8] : ins_node_reg] <= m_wd;
        mark_q <= mark_mem[walk_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.p_fin && !failed_reg) mlen_mem[ins_node_reg] <= depth_reg;
        mlen_q <= mlen_mem[walk_reg];
    end

    always_ff @(posedge aclk) begin
        if (qw_en) queue_mem[tail_reg[NB-1:0]] <= q_wd;
        queue_q <= queue_mem[head_reg[NB-1:0]];
    end

    // Hold the item and the clear sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_reg <= clr_reg + AW'(1);
        end
        if (cmd.load) item_reg <= s_data;
    end

    // Grow the trie
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ncount_reg   <= CW'(1);
            ins_node_reg <= '0;
            depth_reg    <= '0;
            failed_reg   <= 1'b0;
        end else if (cmd.p_upd) begin
            priority if (child0 && p_full) begin
                failed_reg <= 1'b1;
            end else begin
                if (child0) begin
                    ins_node_reg <= ncount_reg[NB-1:0];
                    ncount_reg   <= ncount_reg + CW'(1);
                end else begin
                    ins_node_reg <= goto_q;
                end
                if (depth_reg != 8'hFF) depth_reg <= depth_reg + 8'd1;
            end
        end else if (cmd.p_fin) begin
            ins_node_reg <= '0;
            depth_reg    <= '0;
            failed_reg   <= 1'b0;
        end
    end

    // Walk breadth-first over the trie
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            root_reg <= 1'b1;
        end else begin
            if (cmd.b_init) begin
                head_reg <= '0;
                tail_reg <= '0;
                root_reg <= 1'b1;
                cur_reg  <= '0;
                chr_reg  <= '0;
            end
            if (qw_en) tail_reg <= tail_reg + CW'(1);
            if (cmd.b_child) child_reg <= goto_q;
            if (cmd.b_next && chr_reg != 8'hFF) chr_reg <= chr_reg + 8'd1;
            if (cmd.b_pop && head_reg < tail_reg) head_reg <= head_reg + CW'(1);
            if (cmd.b_cur) begin
                cur_reg  <= queue_q;
                root_reg <= 1'b0;
                chr_reg  <= '0;
            end
            if (cmd.b_fc) fcur_reg <= fail_q;
        end
    end

    // Follow failure links and the output chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg <= '0;
            pos_reg  <= '0;
        end else begin
            if (cmd.b_child && !child0 && !root_reg) begin
                walk_reg  <= fcur_reg;
                steps_reg <= '0;
            end
            if (cmd.t_init) begin
                posc_reg  <= pos_base;
                pos_reg   <= pos_inc;
                walk_reg  <= item_reg.first ? '0 : scan_reg;
                steps_reg <= '0;
            end
            if (cmd.fb_edge && child0) begin
                if (steps_full) walk_reg <= '0;
                else steps_reg <= steps_reg + CW'(1);
            end
            if (cmd.fb_fail) walk_reg <= fail_q;
            if (cmd.e_use && !is_build) begin
                scan_reg  <= goto_q;
                walk_reg  <= goto_q;
                steps_reg <= '0;
            end
            if (cmd.c_chk) steps_reg <= steps_reg + CW'(1);
            if (cmd.c_ev && !mark_q) walk_reg <= fail_q;
        end
    end

    // Build the pending result
    always_comb begin
        res_next = res_reg;
        priority if (cmd.p_fin) begin
            res_next = '0;
            if (failed_reg) begin
                res_next.kind = KIND_FULL;
            end else begin
                res_next.kind           = KIND_STORED;
                res_next.pattern_node   = 8'(ins_node_reg);
                res_next.pattern_length = depth_reg;
            end
        end else if (cmd.b_pop) begin
            res_next      = '0;
            res_next.kind = KIND_BUILT;
        end else if (cmd.c_ev) begin
            res_next.kind           = KIND_MATCH;
            res_next.match_start    = 32'(posp1 - PW'(mlen_q));
            res_next.end_index      = 32'(posc_reg);
            res_next.pattern_node   = 8'(walk_reg);
            res_next.pattern_length = mlen_q;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    // Output register: load when free, drop on acceptance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.emit && out_free) m_data_reg <= res_reg;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        stat.clr_done    = (clr_reg == AW'(GD - 1));
        stat.op          = item_reg.op;
        stat.last        = item_reg.last;
        stat.ins_failed  = failed_reg;
        stat.out_free    = out_free;
        stat.child_zero  = child0;
        stat.is_root     = root_reg;
        stat.chr_last    = (chr_reg == 8'hFF);
        stat.queue_empty = (head_reg >= tail_reg);
        stat.walk_zero   = (walk_reg == '0);
        stat.steps_full  = steps_full;
        stat.is_build    = is_build;
        stat.mark        = mark_q;
        stat.len_ok      = (PW'(mlen_q) <= posp1);
    end

endmodule

// File: dv/multi_pattern_string_matcher_tb.sv
// Self-checking testbench for the multi-pattern string matcher.
// Depends on msm_pkg and multi_pattern_string_matcher, and through it on msm_ctrl and msm_dp.
module multi_pattern_string_matcher_tb;
    import msm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors = 0;
    int words_sent = 0;
    int results_seen = 0;
    int matches_seen = 0;
    int full_seen = 0;
    bit draining = 1'b0;

    out_t pending_results[$];

    // Mirror of the matcher's tables and scan state
    logic [7:0]      trie_edge [0:65535];
    logic [7:0]      fail_link [0:255];
    bit              node_marked [0:255];
    logic [7:0]      node_len [0:255];
    int unsigned     node_total;
    logic [7:0]      grow_node;
    int unsigned     grow_depth;
    bit              grow_failed;
    logic [7:0]      cursor;
    longint unsigned text_pos;

    localparam longint unsigned POS_LIMIT = 64'hFFFF_FFFF;

    typedef struct {
        in_t  word;
        bit   fixed;
        out_t want;
    } row_t;

    row_t rows[$];

    multi_pattern_string_matcher dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Follow failure links until an edge on byte b exists or the top is reached
    function automatic logic [7:0] retreat(logic [7:0] n, logic [7:0] b);
        int steps;
        steps = 0;
        while (n != 8'd0 && trie_edge[{n, b}] == 8'd0) begin
            if (steps >= 256) return 8'd0;
            steps++;
            n = fail_link[n];
        end
        return n;
    endfunction

    // Breadth-first pass that recomputes every failure link
    function automatic void link_trie();
        logic [7:0] bfs[$];
        logic [7:0] cur;
        logic [7:0] ch;
        int         tail;
        tail = 0;
        fail_link[0] = 8'd0;
        for (int c = 0; c < 256; c++) begin
            ch = trie_edge[{8'd0, 8'(c)}];
            if (ch != 8'd0 && tail < 256) begin
                fail_link[ch] = 8'd0;
                bfs.push_back(ch);
                tail++;
            end
        end
        while (bfs.size() > 0) begin
            cur = bfs.pop_front();
            for (int c = 0; c < 256; c++) begin
                ch = trie_edge[{cur, 8'(c)}];
                if (ch == 8'd0) continue;
                fail_link[ch] = trie_edge[{retreat(fail_link[cur], 8'(c)), 8'(c)}];
                if (tail < 256) begin
                    bfs.push_back(ch);
                    tail++;
                end
            end
        end
    endfunction

    function automatic void clear_trie();
        foreach (trie_edge[i]) trie_edge[i] = 8'd0;
        foreach (fail_link[i]) begin
            fail_link[i] = 8'd0;
            node_marked[i] = 1'b0;
            node_len[i] = 8'd0;
        end
        node_total = 1;
        grow_node = 8'd0;
        grow_depth = 0;
        grow_failed = 1'b0;
        cursor = 8'd0;
        text_pos = 0;
    endfunction

    // Advance the mirror by one word; return 1 when the word yields a result
    function automatic bit trie_step(in_t w, output out_t r);
        logic [7:0]      child;
        logic [7:0]      t;
        longint unsigned pos;
        int              steps;
        r = '0;
        if (w.op == OP_PATTERN) begin
            if (!grow_failed) begin
                child = trie_edge[{grow_node, w.data}];
                if (child == 8'd0) begin
                    if (node_total >= 256) grow_failed = 1'b1;
                    else begin
                        child = 8'(node_total);
                        node_total++;
                        trie_edge[{grow_node, w.data}] = child;
                    end
                end
                if (!grow_failed) begin
                    grow_node = child;
                    if (grow_depth < 255) grow_depth++;
                end
            end
            if (!w.last) return 1'b0;
            if (grow_failed) r.kind = KIND_FULL;
            else begin
                node_marked[grow_node] = 1'b1;
                node_len[grow_node] = 8'(grow_depth);
                r.kind = KIND_STORED;
                r.pattern_node = grow_node;
                r.pattern_length = 8'(grow_depth);
            end
            grow_node = 8'd0;
            grow_depth = 0;
            grow_failed = 1'b0;
            return 1'b1;
        end
        if (w.op == OP_BUILD) begin
            link_trie();
            r.kind = KIND_BUILT;
            return 1'b1;
        end
        if (w.op == OP_TEXT) begin
            if (w.first) begin
                cursor = 8'd0;
                text_pos = 0;
            end
            pos = text_pos;
            if (text_pos < POS_LIMIT) text_pos++;
            cursor = trie_edge[{retreat(cursor, w.data), w.data}];
            t = cursor;
            steps = 0;
            while (t != 8'd0 && steps < 256) begin
                steps++;
                if (node_marked[t]) begin
                    if (node_len[t] <= pos + 1) begin
                        r.kind = KIND_MATCH;
                        r.match_start = 32'(pos + 1 - node_len[t]);
                        r.end_index = 32'(pos);
                        r.pattern_node = t;
                        r.pattern_length = node_len[t];
                        return 1'b1;
                    end
                    return 1'b0;
                end
                t = fail_link[t];
            end
        end
        return 1'b0;
    endfunction

    // Drive one word and wait for its handshake; valid stays up for back-to-back words
    task automatic send_word(in_t w, bit fixed, out_t want);
        out_t r;
        bit   has;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        has = trie_step(w, r);
        if (fixed) pending_results.push_back(want);
        else if (has) pending_results.push_back(r);
    endtask

    task automatic send_plain(logic [1:0] op, logic [7:0] data, bit last, bit first);
        in_t w;
        w.op = op;
        w.data = data;
        w.last = last;
        w.first = first;
        send_word(w, 1'b0, '0);
    endtask

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(9) == 0) return 8'($urandom);
        return 8'h61 + 8'($urandom_range(3));
    endfunction

    task automatic send_pattern(int len);
        for (int i = 0; i < len; i++)
            send_plain(OP_PATTERN, pick_byte(), i == len - 1, 1'($urandom));
    endtask

    // Random traffic: a few patterns and a build, then mostly text
    task automatic run_phase(int n);
        int done;
        int pick;
        int len;
        done = 0;
        repeat (4) begin
            len = $urandom_range(1, 3);
            send_pattern(len);
            done += len;
        end
        send_plain(OP_BUILD, 8'($urandom), 1'($urandom), 1'($urandom));
        while (done < n) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                len = $urandom_range(1, 3);
                send_pattern(len);
                done += len;
            end else if (pick < 6) begin
                send_plain(OP_BUILD, 8'($urandom), 1'($urandom), 1'($urandom));
                done++;
            end else if (pick < 10) begin
                send_plain(OP_NOP, 8'($urandom), 1'($urandom), 1'($urandom));
            end else begin
                send_plain(OP_TEXT, pick_byte(), 1'($urandom), $urandom_range(19) == 0);
                done++;
            end
        end
    endtask

    task automatic add_row(logic [1:0] op, logic [7:0] data, bit last, bit first,
                           bit fixed, logic [1:0] kind, logic [7:0] node,
                           logic [7:0] len);
        row_t rw;
        rw.word.op = op;
        rw.word.data = data;
        rw.word.last = last;
        rw.word.first = first;
        rw.fixed = fixed;
        rw.want = '0;
        rw.want.kind = kind;
        rw.want.pattern_node = node;
        rw.want.pattern_length = len;
        rows.push_back(rw);
    endtask

    // Check each result word against the oldest expectation; vary the stall
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_data.kind == KIND_MATCH) matches_seen++;
            if (m_data.kind == KIND_FULL) full_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, m_data);
                errors++;
            end else if (m_data !== pending_results[0]) begin
                $display("%0t: mismatch expected %h actual %h", $time,
                         pending_results[0], m_data);
                if (m_data.kind !== pending_results[0].kind)
                    $display("  kind expected %0d actual %0d",
                             pending_results[0].kind, m_data.kind);
                if (m_data.match_start !== pending_results[0].match_start)
                    $display("  match_start expected %0d actual %0d",
                             pending_results[0].match_start, m_data.match_start);
                if (m_data.end_index !== pending_results[0].end_index)
                    $display("  end_index expected %0d actual %0d",
                             pending_results[0].end_index, m_data.end_index);
                if (m_data.pattern_node !== pending_results[0].pattern_node)
                    $display("  pattern_node expected %0d actual %0d",
                             pending_results[0].pattern_node, m_data.pattern_node);
                if (m_data.pattern_length !== pending_results[0].pattern_length)
                    $display("  pattern_length expected %0d actual %0d",
                             pending_results[0].pattern_length, m_data.pattern_length);
                errors++;
                void'(pending_results.pop_front());
            end else begin
                void'(pending_results.pop_front());
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct) || draining;
    end

    // Hard stop in case the block hangs
    initial begin
        #500_000_000;
        $display("multi_pattern_string_matcher_tb failed");
        $finish;
    end

    initial begin
        int waited;
        clear_trie();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty trie, classic pattern set, extreme bytes, ignored op
        add_row(OP_TEXT,    8'h61, 1'b0, 1'b1, 1'b0, 2'd0,        8'd0,  8'd0);
        add_row(OP_BUILD,   8'hFF, 1'b1, 1'b1, 1'b1, KIND_BUILT,  8'd0,  8'd0);
        add_row(OP_PATTERN, "h",   1'b0, 1'b1, 1'b0, 2'd0,        8'd0,  8'd0);
        add_row(OP_PATTERN, "e",   1'b1, 1'b0, 1'b1, KIND_STORED, 8'd2,  8'd2);
        add_row(OP_PATTERN, "s",   1'b0, 1'b0, 1'b0, 2'd0,        8'd0,  8'd0);
        add_row(OP_PATTERN, "h",   1'b0, 1'b0, 1'b0, 2'd0,        8'd0,  8'd0);
        add_row(OP_PATTERN, "e",   1'b1, 1'b0, 1'b1, KIND_STORED, 8'd5,  8'd3);
        add_row(OP_PATTERN, "h",   1'b0, 1'b0, 1'b0, 2'd0,        8'd0,  8'd0);
        add_row(OP_PATTERN, "i",   1'b0, 1'b0, 1'b0, 2'd0,        8'd0,  8'd0);
        add_row(OP_PATTERN, "s",   1'b1, 1'b0, 1'b1, KIND_STORED, 8'd7,  8'd3);
        add_row(OP_PATTERN, "h",   1'b0, 1'b0, 1'b0, 2'd0,        8'd0,  8'd0);
        add_row(OP_PATTERN, "e",   1'b1, 1'b0, 1'b1, KIND_STORED, 8'd2,  8'd2);
        add_row(OP_PATTERN, 8'hFF, 1'b1, 1'b0, 1'b1, KIND_STORED, 8'd8,  8'd1);
        add_row(OP_PATTERN, 8'h00, 1'b1, 1'b0, 1'b1, KIND_STORED, 8'd9,  8'd1);
        add_row(OP_NOP,     8'hA5, 1'b1, 1'b1, 1'b0, 2'd0,        8'd0,  8'd0);
        add_row(OP_BUILD,   8'h00, 1'b0, 1'b0, 1'b1, KIND_BUILT,  8'd0,  8'd0);
        add_row(OP_TEXT,    "u",   1'b1, 1'b1, 1'b0, 2'd0,        8'd0,  8'd0);
        add_row(OP_TEXT,    "s",   1'b0, 1'b0, 1'b0, 2'd0,        8'd0,  8'd0);
        add_row(OP_TEXT,    "h",   1'b0, 1'b0, 1'b0, 2'd0,        8'd0,  8'd0);
        add_row(OP_TEXT,    "e",   1'b0, 1'b0, 1'b0, 2'd0,        8'd0,  8'd0);
        add_row(OP_TEXT,    8'hFF, 1'b0, 1'b0, 1'b0, 2'd0,        8'd0,  8'd0);
        add_row(OP_TEXT,    8'h00, 1'b1, 1'b0, 1'b0, 2'd0,        8'd0,  8'd0);
        add_row(OP_PATTERN, "s",   1'b1, 1'b1, 1'b0, 2'd0,        8'd0,  8'd0);
        add_row(OP_TEXT,    "s",   1'b0, 1'b1, 1'b0, 2'd0,        8'd0,  8'd0);
        add_row(OP_TEXT,    "h",   1'b0, 1'b0, 1'b0, 2'd0,        8'd0,  8'd0);

        send_idle_pct = 18;
        recv_idle_pct = 86;
        foreach (rows[i]) send_word(rows[i].word, rows[i].fixed, rows[i].want);

        run_phase(90);
        send_idle_pct = 86;
        recv_idle_pct = 18;
        run_phase(90);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(90);

        // Overfill the node table with long random patterns, then scan without a build
        repeat (9)
            for (int i = 0; i < 30; i++)
                send_plain(OP_PATTERN, 8'($urandom), i == 29, 1'b0);
        repeat (30) send_plain(OP_TEXT, pick_byte(), 1'b0, 1'b0);
        s_valid <= 1'b0;

        // Drain outstanding results, then allow trailing text walks to settle
        draining = 1'b1;
        waited = 0;
        while (pending_results.size() > 0 && waited < 2_000_000) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_results.size() > 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     pending_results.size());
            errors++;
        end
        repeat (2000) @(posedge aclk);

        $display("Sent %0d words; checked %0d results (%0d matches, %0d table-full).",
                 words_sent, results_seen, matches_seen, full_seen);
        $display("Trie ended with %0d nodes across three handshake pacing phases.",
                 node_total);
        if (errors == 0) begin
            $display("multi_pattern_string_matcher_tb passed");
        end else begin
            $display("multi_pattern_string_matcher_tb failed");
        end
        $finish;
    end
endmodule

// File: multi_pattern_string_matcher.f
design/msm_pkg.sv
design/msm_ctrl.sv
design/msm_dp.sv
design/multi_pattern_string_matcher.sv
dv/multi_pattern_string_matcher_tb.sv
